// ===== hw/rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, codes and helpers for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

   localparam int HEAP_DEPTH_DEFAULT = 64;

   localparam int FIELD_W = 16;
   localparam int KEY_W   = 2 * FIELD_W;

   // Operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] id;
      logic [FIELD_W-1:0] prio;
      logic [FIELD_W-1:0] aux;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_PUT,
      ST_DN_ROOT,
      ST_DN_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DONE
   } state_type;

   // Ordering key: primary priority, then id
   function automatic logic [KEY_W-1:0] job_key(input job_type j);
      return {j.prio, j.id};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of jobs ordered by (priority, id), held in one RAM and
// sifted by a small sequencer that compares (priority, id) keys.
// ----------------------------------------------------------------------------
// Sequence (accept to rsp_valid): full or empty cases go straight to DONE;
//   enqueue reads parents in UP, then PUT; dequeue reads root and last job,
//   then left and right children per level (sharing the one RAM read port).
// Throughput: one item at a time; req_ready is high only while idle, so a new
//   item is taken only once the last one's response has left DONE.
// Reset: synchronous, clears job count and control state; RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue
   import hpq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_opcode,
   input  wire logic [FIELD_W-1:0]              req_new_id,
   input  wire logic [FIELD_W-1:0]              req_new_priority,
   input  wire logic [FIELD_W-1:0]              req_new_aux_priority,
   // response channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [1:0]                      rsp_status,
   output      logic [FIELD_W-1:0]              rsp_out_id,
   output      logic [FIELD_W-1:0]              rsp_out_priority,
   output      logic [FIELD_W-1:0]              rsp_out_aux_priority,
   output      logic [$clog2(HEAP_DEPTH+1)-1:0] rsp_occupancy
);

   localparam int AW = $clog2(HEAP_DEPTH);     // RAM address
   localparam int CW = $clog2(HEAP_DEPTH + 1); // job count
   localparam int IW = AW + 2;                 // child index, may overrun

   // ---------------------------------------------------------------------
   // Index helpers
   // ---------------------------------------------------------------------
   function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
      return (p - AW'(1)) >> 1;
   endfunction

   function automatic logic [IW-1:0] left_of(input logic [AW-1:0] p);
      return (IW'(p) << 1) + IW'(1);
   endfunction

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    pos_ff, pos_in;     // current hole in the heap
   job_type          cur_ff, cur_in;     // job being sifted
   job_type          lbuf_ff, lbuf_in;   // left child during sift-down
   logic [1:0]       res_status_ff, res_status_in;
   job_type          res_job_ff, res_job_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   job_type          rsp_job_ff, rsp_job_in;
   logic [CW-1:0]    rsp_occ_ff, rsp_occ_in;

   // RAM port
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   job_type          ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [JOB_W-1:0] ram_rd_raw;
   job_type          ram_rd_job;

   assign ram_rd_job = job_type'(ram_rd_raw);

   hpq_ram #(
      .WIDTH (JOB_W),
      .DEPTH (HEAP_DEPTH)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // ---------------------------------------------------------------------
   // Sift datapath terms
   // ---------------------------------------------------------------------
   job_type          req_job;
   logic [AW-1:0]    up_idx;       // parent of current hole
   logic [IW-1:0]    left_idx;     // children of current hole
   logic [IW-1:0]    right_idx;
   logic             has_left;
   logic             has_right;
   logic             pick_right;
   job_type          best_job;
   logic [AW-1:0]    best_idx;
   logic [IW-1:0]    next_left;

   assign req_job    = '{id: req_new_id, prio: req_new_priority,
                         aux: req_new_aux_priority};
   assign up_idx     = parent_of(pos_ff);
   assign left_idx   = left_of(pos_ff);
   assign right_idx  = left_idx + IW'(1);
   assign has_left   = left_idx < IW'(count_ff);
   assign has_right  = right_idx < IW'(count_ff);
   // Larger child wins; on equal keys the left one is kept
   assign pick_right = has_right && (job_key(ram_rd_job) > job_key(lbuf_ff));
   assign best_job   = pick_right ? ram_rd_job : lbuf_ff;
   assign best_idx   = pick_right ? AW'(right_idx) : AW'(left_idx);
   assign next_left  = left_of(best_idx);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      lbuf_ff       <= lbuf_in;
      res_status_ff <= res_status_in;
      res_job_ff    <= res_job_in;
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      lbuf_in       = lbuf_ff;
      res_status_in = res_status_ff;
      res_job_in    = res_job_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = cur_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = up_idx;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_status_in = STATUS_OK;
               res_job_in    = '0;
               if (req_opcode == OP_ENQUEUE) begin
                  if (count_ff == CW'(HEAP_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     // new job goes in the hole at the end of the heap
                     cur_in   = req_job;
                     pos_in   = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     if (count_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = parent_of(AW'(count_ff));
                        state_in    = ST_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     count_in    = count_ff - CW'(1);
                     pos_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_DN_ROOT;
                  end
               end
            end
         end

         ST_UP: begin
            // read data is the parent of the hole
            if (job_key(cur_ff) > job_key(ram_rd_job)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_job;
               pos_in      = up_idx;
               if (up_idx == '0) begin
                  state_in = ST_PUT;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = parent_of(up_idx);
               end
            end else begin
               state_in = ST_PUT;
            end
         end

         ST_PUT: begin
            ram_wr_en = 1'b1;
            state_in  = ST_DONE;
         end

         ST_DN_ROOT: begin
            res_job_in  = ram_rd_job;
            // count already decremented: it indexes the last job
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(count_ff);
            state_in    = ST_DN_LAST;
         end

         ST_DN_LAST: begin
            cur_in = ram_rd_job;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else if (has_left) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(left_idx);
               state_in    = ST_DN_LEFT;
            end else begin
               state_in = ST_PUT;
            end
         end

         ST_DN_LEFT: begin
            lbuf_in = ram_rd_job;
            if (has_right) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(right_idx);
            end
            state_in = ST_DN_RIGHT;
         end

         ST_DN_RIGHT: begin
            if (job_key(best_job) > job_key(cur_ff)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = best_job;
               pos_in      = best_idx;
               if (next_left < IW'(count_ff)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(next_left);
                  state_in    = ST_DN_LEFT;
               end else begin
                  state_in = ST_PUT;
               end
            end else begin
               state_in = ST_PUT;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_job_in    = res_job_ff;
               rsp_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_id           = rsp_job_ff.id;
   assign rsp_out_priority     = rsp_job_ff.prio;
   assign rsp_out_aux_priority = rsp_job_ff.aux;
   assign rsp_occupancy        = rsp_occ_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("job count exceeds heap depth");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sift is in progress");

   a_no_write_idle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_wr_en)
      else $error("RAM written while idle");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside of completion");

   a_empty_occ : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_EMPTY |-> rsp_occ_ff == '0)
      else $error("empty dequeue reports nonzero occupancy");

endmodule

`default_nettype wire

// ===== hw/rtl/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
